// File: hw/rtl/wssr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wssr_pkg: shared types and constants of the wheel speed step regulator
// Request payloads, configuration set, controller commands and status.
// ----------------------------------------------------------------------------
package wssr_pkg;

    // Fixed-point fraction width of all speed values
    localparam int FRAC_BITS = 16;

    // Width of the unclamped drive sum: 32-bit drive plus a 1.5x 31-bit step
    localparam int NV_W = 35;

    // Divider iterations: one quotient bit per cycle
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_PER_TICK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_DIR_NEG      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAFE_LIMIT        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ABSOLUTE_LIMIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_THRESHOLD    = 3'd5;

    // Configuration reset values
    localparam logic [31:0] RST_DISTANCE_PER_TICK = 32'd65536;
    localparam logic [30:0] RST_STEP_SIZE         = 31'd65536;
    localparam logic        RST_STEP_DIR_NEG      = 1'b0;
    localparam logic [30:0] RST_SAFE_LIMIT        = 31'd16711680;
    localparam logic [30:0] RST_ABSOLUTE_LIMIT    = 31'd16711680;
    localparam logic [30:0] RST_STOP_THRESHOLD    = 31'd655;

    typedef struct packed {
        logic [31:0]        time_now;
        logic signed [31:0] encoder_count;
        logic signed [31:0] speed_setpoint;
        logic               allow_overclock;
    } in_req_t;

    typedef struct packed {
        logic signed [15:0] drive_command;
        logic signed [31:0] measured_speed;
    } out_req_t;

    typedef struct packed {
        logic [31:0] distance_per_tick;
        logic [30:0] step_size;
        logic        step_direction_negative;
        logic [30:0] safe_limit;
        logic [30:0] absolute_limit;
        logic [30:0] stop_threshold;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic mul;
        logic setup;
        logic div_step;
        logic meas;
        logic adjust;
        logic finish;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic primed;
        logic out_full;
    } dp_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/wssr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wssr_ctrl: sequencing state machine
// Steps one request through multiply, divide, measure, adjust and output.
// ----------------------------------------------------------------------------
module wssr_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire wssr_pkg::dp_status_t status,
    output wssr_pkg::dp_cmd_t        cmd
);
    import wssr_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MUL   = 7'b0000010,
        S_SETUP = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_MEAS  = 7'b0010000,
        S_ADJ   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    // unprimed request only stores time and count
                    if (status.primed)
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_MEAS;
                end
            end
            S_MEAS:
            begin
                cmd.meas   = 1'b1;
                state_next = S_ADJ;
            end
            S_ADJ:
            begin
                cmd.adjust = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!status.out_full)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/wssr_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wssr_dp: regulator datapath
// Deltas, multiplier, restoring divider, drive adjustment and output register.
// ----------------------------------------------------------------------------
module wssr_dp (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire wssr_pkg::cfg_t      cfg,
    input  wire wssr_pkg::in_req_t   in_data,
    input  wire wssr_pkg::dp_cmd_t   cmd,
    output wssr_pkg::dp_status_t     status,
    output wssr_pkg::out_req_t       out_data,
    output logic                     out_valid,
    input  wire logic                out_stall
);
    import wssr_pkg::*;

    // history and loop state
    logic [31:0]        last_time_reg, last_time_next;
    logic [31:0]        last_count_reg, last_count_next;
    logic signed [31:0] meas_reg, meas_next;
    logic signed [31:0] drive_reg, drive_next;

    // per-request working registers
    logic [31:0]             tdiff_reg, tdiff_next;
    logic [31:0]             emag_reg, emag_next;
    logic                    eneg_reg, eneg_next;
    logic signed [31:0]      target_reg, target_next;
    logic                    ovc_reg, ovc_next;
    logic                    stop_reg, stop_next;
    logic [63:0]             mag_reg, mag_next;
    logic [31:0]             rem_reg, rem_next;
    logic [31:0]             quo_reg, quo_next;
    logic                    ovf_reg, ovf_next;
    logic signed [NV_W-1:0]  nv_reg, nv_next;
    out_req_t                out_reg, out_next;
    logic                    out_valid_reg, out_valid_next;

    // combinational helpers
    logic [31:0]            tdiff_in;
    logic [31:0]            ediff_in;
    logic [31:0]            tmag_in;
    logic [32:0]            div_shift;
    logic [32:0]            div_sub;
    logic                   qsat;
    logic signed [32:0]     err;
    logic                   err_zero;
    logic                   err_pos;
    logic [NV_W-1:0]        step_w;
    logic [NV_W-1:0]        big_step_w;
    logic signed [NV_W-1:0] drive_w;
    logic [30:0]            limit;
    logic signed [NV_W-1:0] limit_pos;
    logic signed [NV_W-1:0] limit_neg;
    logic signed [NV_W-1:0] clamped;
    logic [31:0]            cmag;
    logic [31:0]            imag;
    logic signed [15:0]     drive_cmd;

    assign tdiff_in = in_data.time_now - last_time_reg;
    assign ediff_in = in_data.encoder_count - last_count_reg;
    assign tmag_in  = in_data.speed_setpoint[31] ? (32'd0 - in_data.speed_setpoint)
                                                 : in_data.speed_setpoint;

    assign div_shift = {rem_reg, quo_reg[31]};
    assign div_sub   = div_shift - {1'b0, tdiff_reg};
    assign qsat      = ovf_reg | quo_reg[31];

    assign err        = {meas_reg[31], meas_reg} - {target_reg[31], target_reg};
    assign err_zero   = (err == '0);
    assign err_pos    = !err[32] && !err_zero;
    assign step_w     = NV_W'(cfg.step_size);
    assign big_step_w = NV_W'(cfg.step_size) + NV_W'(cfg.step_size[30:1]);
    assign drive_w    = NV_W'(drive_reg);

    assign limit     = ovc_reg ? cfg.absolute_limit : cfg.safe_limit;
    assign limit_pos = $signed(NV_W'(limit));
    assign limit_neg = -limit_pos;

    always_comb
    begin
        priority if (nv_reg < limit_neg)
        begin
            clamped = limit_neg;
        end
        else if (nv_reg > limit_pos)
        begin
            clamped = limit_pos;
        end
        else
        begin
            clamped = nv_reg;
        end
    end

    // clamped magnitude is below 2^31, truncate toward zero then saturate
    assign cmag = clamped[NV_W-1] ? 32'(-clamped) : 32'(clamped);
    assign imag = cmag >> FRAC_BITS;

    always_comb
    begin
        if (clamped[NV_W-1])
        begin
            drive_cmd = (imag > 32'd32767) ? 16'sh8000 : -$signed(imag[15:0]);
        end
        else
        begin
            drive_cmd = (imag > 32'd32767) ? 16'sh7fff : $signed(imag[15:0]);
        end
    end

    always_comb
    begin
        last_time_next  = last_time_reg;
        last_count_next = last_count_reg;
        meas_next       = meas_reg;
        drive_next      = drive_reg;
        tdiff_next      = tdiff_reg;
        emag_next       = emag_reg;
        eneg_next       = eneg_reg;
        target_next     = target_reg;
        ovc_next        = ovc_reg;
        stop_next       = stop_reg;
        mag_next        = mag_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        ovf_next        = ovf_reg;
        nv_next         = nv_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg & out_stall;

        if (cmd.load_in)
        begin
            last_time_next  = in_data.time_now;
            last_count_next = in_data.encoder_count;
            tdiff_next      = tdiff_in;
            eneg_next       = ediff_in[31];
            emag_next       = ediff_in[31] ? (32'd0 - ediff_in) : ediff_in;
            target_next     = in_data.speed_setpoint;
            ovc_next        = in_data.allow_overclock;
            stop_next       = (tmag_in <= {1'b0, cfg.stop_threshold});
        end

        if (cmd.mul)
        begin
            mag_next = emag_reg * cfg.distance_per_tick;
        end

        if (cmd.setup)
        begin
            // high half at or above the divisor means the quotient needs 33+ bits
            ovf_next = (mag_reg[63:32] >= tdiff_reg);
            rem_next = mag_reg[63:32];
            quo_next = mag_reg[31:0];
        end

        if (cmd.div_step)
        begin
            if (!div_sub[32])
            begin
                rem_next = div_sub[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = div_shift[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
        end

        if (cmd.meas && (tdiff_reg != '0))
        begin
            if (eneg_reg)
            begin
                meas_next = qsat ? 32'sh8000_0000 : -$signed(quo_reg);
            end
            else
            begin
                meas_next = qsat ? 32'sh7fff_ffff : $signed(quo_reg);
            end
        end

        if (cmd.adjust)
        begin
            priority if (err_zero)
            begin
                nv_next = drive_w;
            end
            else if (err_pos ^ cfg.step_direction_negative)
            begin
                nv_next = drive_w - $signed(step_w);
            end
            else
            begin
                nv_next = drive_w + $signed(big_step_w);
            end
        end

        if (cmd.finish)
        begin
            out_valid_next          = 1'b1;
            out_next.measured_speed = meas_reg;
            if (stop_reg)
            begin
                out_next.drive_command = '0;
            end
            else
            begin
                out_next.drive_command = drive_cmd;
                drive_next             = clamped[31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg  <= '0;
            last_count_reg <= '0;
            meas_reg       <= '0;
            drive_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            last_time_reg  <= last_time_next;
            last_count_reg <= last_count_next;
            meas_reg       <= meas_next;
            drive_reg      <= drive_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tdiff_reg  <= tdiff_next;
        emag_reg   <= emag_next;
        eneg_reg   <= eneg_next;
        target_reg <= target_next;
        ovc_reg    <= ovc_next;
        stop_reg   <= stop_next;
        mag_reg    <= mag_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        ovf_reg    <= ovf_next;
        nv_reg     <= nv_next;
        out_reg    <= out_next;
    end

    assign status.primed   = (last_time_reg != '0);
    assign status.out_full = out_valid_reg & out_stall;
    assign out_data        = out_reg;
    assign out_valid       = out_valid_reg;

endmodule

`default_nettype wire

// File: hw/rtl/wheel_speed_step_regulator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wheel_speed_step_regulator: wheel speed measurement and step drive regulator
// Measures wheel speed from encoder and time deltas and steps a drive command
// toward the target speed.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall carry one request: timestamp, encoder count, target
//   speed and overclock flag. A request is taken when in_valid is high and
//   in_stall is low. The very first request after reset (or any request while
//   the stored timestamp is zero) only primes the stored count and time and
//   gives no result.
//   out_valid/out_stall return drive_command and measured_speed; a result is
//   taken when out_valid is high and out_stall is low.
//   cfg_valid/cfg_ready write one register by index; ready is always high,
//   and writes belong in idle periods.
//   Sequence: a primed request passes through a multiply step, a divider
//   setup step, the 32-bit restoring divider (one quotient bit per cycle),
//   then measure, adjust and output. in_stall stays high until the request
//   has left the sequencer, so the next request waits for this one.
//   A waiting result does not block acceptance of the next request; if the
//   receiver still stalls when that next result is ready, the block holds it
//   and stalls the input side.
//   Reset clears stored time, count, measured and drive speed, and loads the
//   configuration registers with their defaults.
// ----------------------------------------------------------------------------
module wheel_speed_step_regulator (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire wssr_pkg::in_req_t                  in_data,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output wssr_pkg::out_req_t                      out_data,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [wssr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [31:0]                        cfg_data
);
    import wssr_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    dp_cmd_t    cmd;
    dp_status_t status;

    // Configuration writes are always taken; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DISTANCE_PER_TICK: cfg_next.distance_per_tick       = cfg_data;
                CFG_STEP_SIZE:         cfg_next.step_size               = cfg_data[30:0];
                CFG_STEP_DIR_NEG:      cfg_next.step_direction_negative = cfg_data[0];
                CFG_SAFE_LIMIT:        cfg_next.safe_limit              = cfg_data[30:0];
                CFG_ABSOLUTE_LIMIT:    cfg_next.absolute_limit          = cfg_data[30:0];
                CFG_STOP_THRESHOLD:    cfg_next.stop_threshold          = cfg_data[30:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.distance_per_tick       <= RST_DISTANCE_PER_TICK;
            cfg_reg.step_size               <= RST_STEP_SIZE;
            cfg_reg.step_direction_negative <= RST_STEP_DIR_NEG;
            cfg_reg.safe_limit              <= RST_SAFE_LIMIT;
            cfg_reg.absolute_limit          <= RST_ABSOLUTE_LIMIT;
            cfg_reg.stop_threshold          <= RST_STOP_THRESHOLD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Sequencer: walks each primed request through the datapath steps
    wssr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: deltas, multiply, divide, drive step, clamp and output register
    wssr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

endmodule

`default_nettype wire

// File: bench/tb_wheel_speed_step_regulator.sv
// ----------------------------------------------------------------------------
// tb_wheel_speed_step_regulator: self-checking bench of the step regulator
// Feeds timestamp/encoder/target requests through the valid/stall input,
// predicts measured speed and drive command in a shadow model of the block
// and compares every returned result in order. Configuration is reprogrammed
// between idle phases, including the register extremes.
// ----------------------------------------------------------------------------
module tb_wheel_speed_step_regulator;
    timeunit 1ns;
    timeprecision 1ps;

    import wssr_pkg::*;

    localparam int SETTLE_CYCLES = 50;     // idle margin after the last result returns
    localparam int QUIET_LIMIT   = 2000;   // cycles with no handshake at all
    localparam int MAX_REPORTS   = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    // ------------------------------------------------------------------
    // Clock, reset and DUT signals
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic     in_valid = 1'b0;
    logic     in_stall;
    in_req_t  in_data  = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    out_req_t out_data;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;

    always #5 clk = ~clk;

    wheel_speed_step_regulator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow state of the regulator and its register set
    // ------------------------------------------------------------------
    cfg_t        shadow_cfg = '{
        distance_per_tick:       RST_DISTANCE_PER_TICK,
        step_size:               RST_STEP_SIZE,
        step_direction_negative: RST_STEP_DIR_NEG,
        safe_limit:              RST_SAFE_LIMIT,
        absolute_limit:          RST_ABSOLUTE_LIMIT,
        stop_threshold:          RST_STOP_THRESHOLD
    };
    logic [31:0] prev_time  = '0;   // zero means the loop is not primed
    logic [31:0] prev_count = '0;
    int          meas_speed = 0;
    int          drive_speed = 0;

    in_req_t  pending_reqs[$];      // requests waiting for the driver
    out_req_t expected_results[$];  // predicted results, oldest first

    bit idle_on = 1'b1;
    int mismatches = 0;

    // Stimulus generator state: last time and count handed to the queue
    logic [31:0] gen_time  = '0;
    logic [31:0] gen_count = '0;

    // Mirror one register write into the shadow register set
    function automatic void shadow_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        case (idx)
            CFG_DISTANCE_PER_TICK: shadow_cfg.distance_per_tick       = data;
            CFG_STEP_SIZE:         shadow_cfg.step_size               = data[30:0];
            CFG_STEP_DIR_NEG:      shadow_cfg.step_direction_negative = data[0];
            CFG_SAFE_LIMIT:        shadow_cfg.safe_limit              = data[30:0];
            CFG_ABSOLUTE_LIMIT:    shadow_cfg.absolute_limit          = data[30:0];
            CFG_STOP_THRESHOLD:    shadow_cfg.stop_threshold          = data[30:0];
            default: ;
        endcase
    endfunction

    // Advance the shadow regulator by one request; report whether a result
    // follows and what it holds.
    function automatic void regulate(input in_req_t req, output bit has_res,
                                     output out_req_t res);
        logic [31:0]        tdiff;
        logic signed [31:0] ediff32;
        logic [63:0]        mag;
        logic [63:0]        quo;
        longint ediff, tgt, err, dirv, lim, stp, sgn, nv, imag, cmd;
        has_res = 1'b0;
        res     = '0;
        if (prev_time != 0)
        begin
            tdiff   = req.time_now - prev_time;
            ediff32 = req.encoder_count - prev_count;
            ediff   = longint'(ediff32);
            // Zero time delta keeps the previous measurement
            if (tdiff != 0)
            begin
                mag = $unsigned(ediff < 0 ? -ediff : ediff)
                      * 64'(shadow_cfg.distance_per_tick);
                quo = mag / 64'(tdiff);
                if (ediff < 0)
                    meas_speed = (quo >= 64'h8000_0000) ? 32'sh8000_0000 : -int'(quo);
                else
                    meas_speed = (quo > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : int'(quo);
            end
            cmd = 0;
            tgt = longint'($signed(req.speed_setpoint));
            // Inside the stop band the command is zero and drive speed holds
            if ((tgt < 0 ? -tgt : tgt) > longint'(shadow_cfg.stop_threshold))
            begin
                err  = longint'(meas_speed) - tgt;
                dirv = shadow_cfg.step_direction_negative ? -1 : 1;
                lim  = req.allow_overclock ? longint'(shadow_cfg.absolute_limit)
                                           : longint'(shadow_cfg.safe_limit);
                stp  = (err * dirv > 0) ? longint'(shadow_cfg.step_size)
                                        : (3 * longint'(shadow_cfg.step_size)) >>> 1;
                sgn  = (err > 0) ? 1 : ((err < 0) ? -1 : 0);
                nv   = longint'(drive_speed) - dirv * sgn * stp;
                if (nv < -lim)
                    nv = -lim;
                if (nv > lim)
                    nv = lim;
                drive_speed = int'(nv);
                imag = (nv < 0 ? -nv : nv) >>> FRAC_BITS;
                if (imag > 32767)
                    imag = (nv < 0) ? 32768 : 32767;
                cmd = (nv < 0) ? -imag : imag;
            end
            res.drive_command  = 16'(cmd);
            res.measured_speed = meas_speed;
            has_res = 1'b1;
        end
        prev_time  = req.time_now;
        prev_count = req.encoder_count;
    endfunction

    // ------------------------------------------------------------------
    // Input driver: present queued requests, predict on acceptance
    // ------------------------------------------------------------------
    int idle_left = 0;

    always @(posedge clk)
    begin
        bit       has_res;
        out_req_t res;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            idle_left = 0;
        end
        else
        begin
            // Predict from the request taken at this edge
            if (in_valid && !in_stall)
            begin
                regulate(in_data, has_res, res);
                if (has_res)
                    expected_results.push_back(res);
            end
            // Hold the payload while stalled; otherwise load the next slot
            if (!in_valid || !in_stall)
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_reqs.pop_front();
                    // Open an idle burst after this request now and then
                    if (idle_on && $urandom_range(0, 3) == 0)
                        idle_left = $urandom_range(1, 9);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output monitor: random stall bursts, compare against predictions
    // ------------------------------------------------------------------
    int stall_left = 0;

    always @(posedge clk)
    begin
        out_req_t exp_res;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected result drive_command=%0d measured_speed=%0d",
                                 $realtime, out_data.drive_command, out_data.measured_speed);
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (out_data.drive_command !== exp_res.drive_command
                        || out_data.measured_speed !== exp_res.measured_speed)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: mismatch cmd exp %0d got %0d, speed exp %0d got %0d",
                                     $realtime, exp_res.drive_command,
                                     out_data.drive_command, exp_res.measured_speed,
                                     out_data.measured_speed);
                    end
                end
            end
            // Stall in bursts while idle_on is set
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 8);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when nothing moves for too long
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_req(logic [31:0] t, logic [31:0] cnt, logic [31:0] tgt, logic oc);
        in_req_t r;
        r.time_now        = t;
        r.encoder_count   = cnt;
        r.speed_setpoint  = tgt;
        r.allow_overclock = oc;
        pending_reqs.push_back(r);
        gen_time  = t;
        gen_count = cnt;
    endtask

    // Write one register; keep the request up until the block takes it
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        shadow_write(idx, data);
        cfg_valid <= 1'b0;
    endtask

    // Program the whole set; set unused upper bits at random to check masking
    task automatic program_regs(logic [31:0] dpt, logic [30:0] step, logic dneg,
                                logic [30:0] safe, logic [30:0] abs_lim, logic [30:0] stop);
        cfg_write(CFG_DISTANCE_PER_TICK, dpt);
        cfg_write(CFG_STEP_SIZE,         {1'($urandom_range(0, 1)), step});
        cfg_write(CFG_STEP_DIR_NEG,      {31'($urandom), dneg});
        cfg_write(CFG_SAFE_LIMIT,        {1'($urandom_range(0, 1)), safe});
        cfg_write(CFG_ABSOLUTE_LIMIT,    {1'($urandom_range(0, 1)), abs_lim});
        cfg_write(CFG_STOP_THRESHOLD,    {1'($urandom_range(0, 1)), stop});
    endtask

    // Drain: all requests taken, all results back, then let the block settle
    task automatic wait_idle();
        while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly a plausible control stream with random content, some noise
    task automatic queue_random(int n);
        logic [31:0] t, cnt, tgt;
        longint      stop_edge;
        repeat (n)
        begin
            if ($urandom_range(0, 99) < 12)
            begin
                t   = $urandom;
                cnt = $urandom;
                tgt = $urandom;
            end
            else
            begin
                case ($urandom_range(0, 19))
                    0:       t = gen_time;                       // zero time delta
                    1:       t = gen_time + $urandom;            // long jump, may wrap
                    default: t = gen_time + $urandom_range(1, 30);
                endcase
                if ($urandom_range(0, 15) == 0)
                    cnt = $urandom;
                else
                    cnt = gen_count + $urandom_range(0, 2000) - 1000;
                stop_edge = longint'(shadow_cfg.stop_threshold);
                case ($urandom_range(0, 11))
                    0: tgt = $urandom;
                    1: tgt = 32'(($urandom_range(0, 1) ? stop_edge : -stop_edge)
                                 + $urandom_range(0, 2) - 1);   // around the stop band edge
                    2: tgt = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    default: tgt = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
                endcase
            end
            queue_req(t, cnt, tgt, 1'($urandom_range(0, 1)));
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests at reset configuration
        queue_req(32'd100, 32'd0, 32'd0, 1'b0);                 // primes only
        queue_req(32'd110, 32'd100, 32'(5 << 16), 1'b0);        // first measurement
        queue_req(32'd110, 32'd500, -32'(2 << 16), 1'b0);       // zero time delta
        queue_req(32'd110, 32'd500, 32'd655360, 1'b0);          // zero error
        queue_req(32'd120, 32'd600, 32'd655, 1'b0);             // stop band edge
        queue_req(32'd130, 32'd700, -32'd655, 1'b1);            // stop band edge, negative
        queue_req(32'd140, 32'd800, 32'd656, 1'b1);             // just outside the band
        queue_req(32'd150, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1); // huge delta, min target
        queue_req(32'd151, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0); // count wraps by one
        queue_req(32'd152, 32'd0, 32'd0, 1'b0);                 // most negative delta
        queue_req(32'hFFFF_FFF0, 32'd10, 32'(3 << 16), 1'b0);   // long time jump
        queue_req(32'h0000_0010, 32'd20, -32'(3 << 16), 1'b0);  // time wraps
        queue_req(32'd0, 32'd30, 32'(1 << 16), 1'b0);           // zero time unprimes
        queue_req(32'd5, 32'd40, 32'(1 << 16), 1'b0);           // primes again
        queue_req(32'd15, 32'd50, 32'(1 << 16), 1'b1);
        queue_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        queue_req(32'hFFFF_FFFE, 32'h0000_0000, 32'h0000_0000, 1'b0);
        queue_req(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0001, 1'b1);
        queue_random(150);
        wait_idle();

        // No distance, largest step, reversed loop, full safe and zero absolute limit
        program_regs(32'd0, 31'h7FFF_FFFF, 1'b1, 31'h7FFF_FFFF, 31'd0, 31'd0);
        cfg_write(CFG_UNUSED_IDX, $urandom);
        queue_random(200);
        wait_idle();

        // Largest distance, zero step, widest stop band
        program_regs(32'hFFFF_FFFF, 31'd0, 1'b0, 31'(10 << 16), 31'h7FFF_FFFF,
                     31'h7FFF_FFFF);
        queue_random(150);
        wait_idle();

        // Random settings with small limits so the clamp is reached
        program_regs($urandom, 31'($urandom_range(1, 4 << 16)), 1'b1,
                     31'($urandom_range(0, 50 << 16)), 31'($urandom_range(0, 300 << 16)),
                     31'($urandom_range(0, 2 << 16)));
        queue_random(250);
        wait_idle();

        program_regs($urandom_range(1 << 14, 1 << 18), 31'($urandom_range(1, 8 << 16)),
                     1'b0, 31'(20 << 16), 31'(40 << 16), 31'd1000);
        queue_random(250);
        wait_idle();

        // Last phase at full rate: no gaps, no stalls
        idle_on = 1'b0;
        program_regs(32'd65536, 31'(3 << 15), 1'b1, 31'(100 << 16), 31'(200 << 16), 31'd655);
        queue_random(200);
        wait_idle();

        if (mismatches == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
